### hdl/assert_macros.svh
// Assertion macros used by the checker of the hash core (mm3_checker).
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent checked at the same clock edge.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked at the clock edge after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mm3_pkg.sv
// Package for the MurmurHash3 x86_32 stream core: constants, entry codes and the
// record that travels from the front end to the back end. No dependencies.
package mm3_pkg;

  // Mixing and finalizer constants.
  localparam logic [31:0] MIX_C1   = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2   = 32'h1b873593;
  localparam logic [31:0] HASH_ADD = 32'he6546b64;
  localparam logic [31:0] FIN_M1   = 32'h85ebca6b;
  localparam logic [31:0] FIN_M2   = 32'hc2b2ae35;

  // Default depth of the queue between front and back end.
  localparam int FIFO_DEPTH_DEF = 4;

  // Stream widths.
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 32;

  // What the back end does with a queued word.
  localparam logic [1:0] KIND_FULL = 2'd0;  // full block: xor, rotate, multiply-add
  localparam logic [1:0] KIND_TAIL = 2'd1;  // 1..3 byte tail: xor only
  localparam logic [1:0] KIND_NONE = 2'd2;  // empty last item: nothing mixed

  // One classified, pre-mixed word.
  typedef struct packed {
    logic [31:0] k;
    logic [1:0]  kind;
    logic        last;
    logic [2:0]  incr;
  } mm3_entry_t;

endpackage

### hdl/mm3_front.sv
// Front end: accepts stream transfers, classifies each word and runs the
// c1 / rotl15 / c2 mixing in two multiplier stages. Depends on mm3_pkg.
module mm3_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mm3_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [31:0] data_word, [34:32] byte_count
  input  logic                            s_axis_tlast,  // last_item
  output logic                            push,
  output mm3_pkg::mm3_entry_t             push_data,
  input  logic                            fifo_full
);
  import mm3_pkg::*;

  logic        v1;
  logic        v2;
  logic [31:0] k1;
  logic [1:0]  kind1;
  logic        last1;
  logic [2:0]  incr1;
  mm3_entry_t  ent2;

  logic        en1;
  logic        en2;
  logic        s_acc;
  logic [31:0] word;
  logic [2:0]  count;
  logic [31:0] masked;
  logic [1:0]  kind_in;
  logic [2:0]  incr_in;
  logic [31:0] k1_rot;

  // Stall chain: a stage loads when it is empty or its content moves on.
  assign en2           = !v2 || !fifo_full;
  assign en1           = !v1 || en2;
  assign s_axis_tready = en1;
  assign s_acc         = s_axis_tvalid && en1;
  assign push          = v2 && !fifo_full;
  assign push_data     = ent2;

  assign word  = s_axis_tdata[31:0];
  assign count = s_axis_tdata[34:32];

  // Classify the word and drop the bytes above a short tail.
  always_comb begin
    masked  = word;
    kind_in = KIND_FULL;
    incr_in = 3'd4;
    if (s_axis_tlast && !count[2]) begin
      case (count)
        3'd1: begin
          masked  = {24'd0, word[7:0]};
          kind_in = KIND_TAIL;
          incr_in = count;
        end
        3'd2: begin
          masked  = {16'd0, word[15:0]};
          kind_in = KIND_TAIL;
          incr_in = count;
        end
        3'd3: begin
          masked  = {8'd0, word[23:0]};
          kind_in = KIND_TAIL;
          incr_in = count;
        end
        default: begin
          kind_in = KIND_NONE;
          incr_in = 3'd0;
        end
      endcase
    end
  end

  assign k1_rot = {k1[16:0], k1[31:17]};

  // Valid bits of the two stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= s_acc;
      if (en2) v2 <= v1;
    end
  end

  // First stage multiplies by c1, second rotates and multiplies by c2.
  always_ff @(posedge clk) begin
    if (en1) begin
      k1    <= masked * MIX_C1;
      kind1 <= kind_in;
      last1 <= s_axis_tlast;
      incr1 <= incr_in;
    end
    if (en2) begin
      ent2.k    <= k1_rot * MIX_C2;
      ent2.kind <= kind1;
      ent2.last <= last1;
      ent2.incr <= incr1;
    end
  end

endmodule

### hdl/mm3_fifo.sv
// Short queue of mixed words between front and back end, with a registered
// head entry. Depends on mm3_pkg for the entry type.
module mm3_fifo #(
  parameter int DEPTH = mm3_pkg::FIFO_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mm3_pkg::mm3_entry_t push_data,
  output logic                full,
  output logic                head_valid,
  output mm3_pkg::mm3_entry_t head_data,
  input  logic                pop
);
  import mm3_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mm3_entry_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             load;

  assign full = (cnt == CNT_W'(DEPTH));
  // Refill the head whenever it is empty or being taken and storage holds an entry.
  assign load = (cnt != '0) && (!head_valid || pop);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Pointers, occupancy and head valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      cnt        <= '0;
      head_valid <= 1'b0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (load) rd_ptr <= ptr_inc(rd_ptr);
      case ({push, load})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
      if (load) begin
        head_valid <= 1'b1;
      end else if (pop) begin
        head_valid <= 1'b0;
      end
    end
  end

  // Storage write and registered head read.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
    if (load) head_data <= mem[rd_ptr];
  end

endmodule

### hdl/mm3_back.sv
// Back end: folds mixed words into the running hash and length, then runs the
// fmix32 finalizer through a stalling pipeline into the output register. Uses mm3_pkg.
module mm3_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [31:0]                   seed,
  input  logic                          head_valid,
  input  mm3_pkg::mm3_entry_t           head_data,
  output logic                          pop,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mm3_pkg::M_TDATA_W-1:0] m_axis_tdata  // [31:0] hash_value
);
  import mm3_pkg::*;

  logic        in_msg;
  logic [31:0] hash;
  logic [31:0] len;

  logic        v1;
  logic        v2;
  logic        v3;
  logic        vo;
  logic [31:0] b1;
  logic [31:0] m1;
  logic [31:0] m2;
  logic [31:0] out_data;

  logic        en1;
  logic        en2;
  logic        en3;
  logic        en_o;
  logic [31:0] h_cur;
  logic [31:0] len_cur;
  logic [31:0] h_x;
  logic [31:0] h_r;
  logic [31:0] h_new;
  logic [31:0] len_new;
  logic [31:0] h_fin;
  logic [31:0] m1_x;

  // Stall chain from the output register back to the queue head.
  assign en_o = !vo || m_axis_tready;
  assign en3  = !v3 || en_o;
  assign en2  = !v2 || en3;
  assign en1  = !v1 || en2;
  assign pop  = head_valid && en1;

  assign m_axis_tvalid = vo;
  assign m_axis_tdata  = out_data;

  // One hash step per word; a new message starts from the seed.
  always_comb begin
    h_cur   = in_msg ? hash : seed;
    len_cur = in_msg ? len : 32'd0;
    h_x     = h_cur ^ head_data.k;
    h_r     = {h_x[18:0], h_x[31:19]};
    case (head_data.kind)
      KIND_FULL: h_new = (h_r << 2) + h_r + HASH_ADD;
      KIND_TAIL: h_new = h_x;
      default:   h_new = h_cur;
    endcase
    len_new = len_cur + {29'd0, head_data.incr};
    h_fin   = h_new ^ len_new;
  end

  assign m1_x = m1 ^ (m1 >> 13);

  // Message state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_msg <= 1'b0;
      hash   <= '0;
      len    <= '0;
    end else if (pop) begin
      if (head_data.last) begin
        in_msg <= 1'b0;
        len    <= '0;
      end else begin
        in_msg <= 1'b1;
        hash   <= h_new;
        len    <= len_new;
      end
    end
  end

  // Finalizer valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (en1)  v1 <= pop && head_data.last;
      if (en2)  v2 <= v1;
      if (en3)  v3 <= v2;
      if (en_o) vo <= v3;
    end
  end

  // fmix32: shift-xor, multiply, shift-xor, multiply, shift-xor.
  always_ff @(posedge clk) begin
    if (en1)  b1       <= h_fin ^ (h_fin >> 16);
    if (en2)  m1       <= b1 * FIN_M1;
    if (en3)  m2       <= m1_x * FIN_M2;
    if (en_o) out_data <= m2 ^ (m2 >> 16);
  end

endmodule

### hdl/murmur3_32bit_stream_hash_core.sv
// MurmurHash3 x86_32 over a stream of 32-bit words.
// The slave stream carries data_word in tdata[31:0], byte_count in tdata[34:32]
// and last_item on tlast; a transfer happens when tvalid and tready are both high.
// Every word but the last is hashed as four bytes; the last carries 0 to 4 bytes.
// One result per message appears on the master stream, hash_value in tdata[31:0].
// cfg_we / cfg_wdata write the seed, sampled when a message's first word is hashed.
// Throughput: one word per cycle while the receiver keeps up. The front end
// mixes words in two multiplier stages; the back end folds one word per cycle
// into the hash, which is the loop that sets the rate, then runs the finalizer
// in further stages that end in the output register. A word passes the front
// stages, the queue and its head register before it is folded. A short queue
// lets the front keep accepting while the back end waits on a stalled receiver;
// tready drops only when the queue and both front stages are full. A stalled result holds its tdata.
// Reset (rst, synchronous) empties all stages, clears the seed to zero and
// starts a new message; no clearing pass is needed.
// Depends on mm3_pkg, mm3_front, mm3_fifo and mm3_back.
module murmur3_32bit_stream_hash_core #(
  parameter int FIFO_DEPTH = mm3_pkg::FIFO_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mm3_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [31:0] data_word, [34:32] byte_count
  input  logic                          s_axis_tlast,  // last_item
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mm3_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [31:0] hash_value
  input  logic                          cfg_we,
  input  logic [31:0]                   cfg_wdata
);
  import mm3_pkg::*;

  logic        [31:0] seed;
  logic               push;
  mm3_entry_t         push_data;
  logic               fifo_full;
  logic               head_valid;
  mm3_entry_t         head_data;
  logic               pop;

  // Seed register.
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_we) begin
      seed <= cfg_wdata;
    end
  end

  mm3_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .push          (push),
    .push_data     (push_data),
    .fifo_full     (fifo_full)
  );

  mm3_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (fifo_full),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  mm3_back u_back (
    .clk           (clk),
    .rst           (rst),
    .seed          (seed),
    .head_valid    (head_valid),
    .head_data     (head_data),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

### hdl/mm3_checker.sv
// Port-level checker for the hash core, attached to the top level by bind.
// Depends on assert_macros.svh and mm3_pkg.
`include "assert_macros.svh"

module mm3_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tlast,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mm3_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic [15:0] pend;
  logic [15:0] pend_next;

  // Messages whose last transfer was taken but whose hash was not yet sent.
  always_comb begin
    pend_next = pend;
    if (s_axis_tvalid && s_axis_tready && s_axis_tlast) pend_next = pend_next + 1'b1;
    if (m_axis_tvalid && m_axis_tready) pend_next = pend_next - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend_next;
    end
  end

  // A result must belong to a finished message.
  `ASSERT_IMPL(a_result_has_msg, m_axis_tvalid, pend != 16'd0, "hash without a finished message")
  // A stalled result holds.
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  // Right after reset nothing is presented and the input side is open.
  `ASSERT_IMPL(a_reset_out_idle, $past(rst), !m_axis_tvalid, "result present after reset")
  `ASSERT_IMPL(a_reset_in_ready, $past(rst), s_axis_tready, "input not ready after reset")

endmodule

bind murmur3_32bit_stream_hash_core mm3_checker u_mm3_checker (.*);
